FILE: hw/rtl/spq_pkg.sv
// Shared types, codes and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH_DEFAULT = 8;
   localparam int VALUE_W = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 4;
   localparam int SLOT_W = 3;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic command;
      logic signed [VALUE_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0] entry_count;
      logic signed [VALUE_W-1:0] top_value;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_UPDATE
   } state_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic commit;
   } ctrl_type;

endpackage

FILE: hw/rtl/spq_ctrl.sv
// Controller state machine that sequences each transaction through compare and update.
`timescale 1ns / 1ps

module spq_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output spq_pkg::ctrl_type ctrl
);

   spq_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spq_pkg::S_IDLE: begin
            if (req_valid) state_in = spq_pkg::S_COMPARE;
         end
         spq_pkg::S_COMPARE: begin
            state_in = spq_pkg::S_UPDATE;
         end
         spq_pkg::S_UPDATE: begin
            if (out_free) begin
               state_in = req_valid ? spq_pkg::S_COMPARE : spq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ctrl.compare = 1'b0;
      ctrl.commit = 1'b0;
      case (state_ff)
         spq_pkg::S_IDLE: begin
            req_ready = 1'b1;
         end
         spq_pkg::S_COMPARE: begin
            ctrl.compare = 1'b1;
         end
         spq_pkg::S_UPDATE: begin
            req_ready = out_free;
            ctrl.commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      ctrl.load = req_valid && req_ready;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/spq_datapath.sv
// Datapath holding the sorted entries, the compare flags and the result register.
`timescale 1ns / 1ps

module spq_datapath #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  spq_pkg::ctrl_type ctrl,
   input  spq_pkg::req_type req_data,
   output spq_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   spq_pkg::req_type req_ff;
   logic signed [spq_pkg::VALUE_W-1:0] entries_ff [DEPTH];
   logic signed [spq_pkg::VALUE_W-1:0] entries_in [DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [DEPTH-1:0] ge_ff, ge_in;
   logic [DEPTH-1:0] eq_ff, eq_in;
   spq_pkg::rsp_type rsp_ff, rsp_in;

   logic [IW-1:0] ins_pos;
   logic [IW-1:0] del_pos;
   logic found;
   logic is_full;
   logic is_empty;

   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         ge_in[k] = (CW'(k) < count_ff) && (req_ff.item_value >= entries_ff[k]);
         eq_in[k] = (CW'(k) < count_ff) && (req_ff.item_value == entries_ff[k]);
      end
   end

   always_comb begin
      ins_pos = IW'(count_ff);
      del_pos = '0;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         if (ge_ff[k]) ins_pos = IW'(k);
         if (eq_ff[k]) del_pos = IW'(k);
      end
   end

   assign found = |eq_ff;
   assign is_full = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         entries_in[k] = entries_ff[k];
      end
      count_in = count_ff;
      rsp_in.status = spq_pkg::ST_OK;
      rsp_in.slot = '0;
      if (req_ff.command == spq_pkg::CMD_INSERT) begin
         if (is_full) begin
            rsp_in.status = spq_pkg::ST_OVERFLOW;
         end else begin
            for (int k = 0; k < DEPTH; k++) begin
               if (IW'(k) == ins_pos) begin
                  entries_in[k] = req_ff.item_value;
               end else if ((IW'(k) > ins_pos) && (k > 0)) begin
                  entries_in[k] = entries_ff[(k > 0) ? k - 1 : 0];
               end
            end
            count_in = count_ff + CW'(1);
            rsp_in.slot = spq_pkg::SLOT_W'(ins_pos);
         end
      end else begin
         if (is_empty) begin
            rsp_in.status = spq_pkg::ST_EMPTY;
         end else if (!found) begin
            rsp_in.status = spq_pkg::ST_NOT_FOUND;
         end else begin
            for (int k = 0; k < DEPTH - 1; k++) begin
               if (IW'(k) >= del_pos) begin
                  entries_in[k] = entries_ff[k + 1];
               end
            end
            count_in = count_ff - CW'(1);
            rsp_in.slot = spq_pkg::SLOT_W'(del_pos);
         end
      end
      rsp_in.entry_count = spq_pkg::COUNT_W'(count_in);
      rsp_in.top_value = (count_in == '0) ? '0 : entries_in[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_ff <= req_data;
      end
      if (ctrl.compare) begin
         ge_ff <= ge_in;
         eq_ff <= eq_in;
      end
      if (ctrl.commit) begin
         rsp_ff <= rsp_in;
         for (int k = 0; k < DEPTH; k++) begin
            entries_ff[k] <= entries_in[k];
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller, datapath and checks.
// A transaction passes through a registered compare step and then the shift-and-write step
// over the entry row; the next transaction is accepted only in the update step of the one before, or when idle.
// A result waiting at the output holds the update step and the next accept until it is taken.
// Reset empties the queue and clears all control state; stored values are not cleared.
`timescale 1ns / 1ps

module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  spq_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output spq_pkg::rsp_type rsp_data
);

   spq_pkg::ctrl_type ctrl;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a transaction while one was in the compare step");

   a_slot_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != spq_pkg::ST_OK)) |-> (rsp_data.slot == '0))
      else $error("failed transaction reports a nonzero slot");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == spq_pkg::ST_OVERFLOW))
         |-> (rsp_data.entry_count == spq_pkg::COUNT_W'(DEPTH)))
      else $error("overflow reported while the queue was not full");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == spq_pkg::ST_EMPTY))
         |-> ((rsp_data.entry_count == '0) && (rsp_data.top_value == '0)))
      else $error("empty status with stored entries or a nonzero top value");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the sorted priority queue with a built-in queue predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   spq_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   spq_pkg::rsp_type rsp_data;

   logic signed [spq_pkg::VALUE_W-1:0] stored_values [QUEUE_DEPTH];
   int stored_count = 0;
   spq_pkg::rsp_type expected_results [$];
   spq_pkg::rsp_type want_rsp;
   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic filling = 1'b1;

   sorted_priority_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   function automatic spq_pkg::rsp_type apply_queue_command(input spq_pkg::req_type txn);
      spq_pkg::rsp_type result;
      int pos;
      int k;
      logic hit;
      result = '0;
      result.status = spq_pkg::ST_OK;
      if (txn.command == spq_pkg::CMD_INSERT) begin
         if (stored_count >= QUEUE_DEPTH) begin
            result.status = spq_pkg::ST_OVERFLOW;
         end else begin
            pos = stored_count;
            hit = 1'b0;
            for (k = 0; k < stored_count; k++) begin
               if (!hit && $signed(txn.item_value) >= $signed(stored_values[k])) begin
                  pos = k;
                  hit = 1'b1;
               end
            end
            for (k = stored_count; k > pos; k--) begin
               stored_values[k] = stored_values[k-1];
            end
            stored_values[pos] = txn.item_value;
            stored_count++;
            result.slot = spq_pkg::SLOT_W'(pos);
         end
      end else begin
         if (stored_count == 0) begin
            result.status = spq_pkg::ST_EMPTY;
         end else begin
            pos = 0;
            hit = 1'b0;
            for (k = 0; k < stored_count; k++) begin
               if (!hit && stored_values[k] == txn.item_value) begin
                  pos = k;
                  hit = 1'b1;
               end
            end
            if (!hit) begin
               result.status = spq_pkg::ST_NOT_FOUND;
            end else begin
               for (k = pos; k + 1 < stored_count; k++) begin
                  stored_values[k] = stored_values[k+1];
               end
               stored_count--;
               result.slot = spq_pkg::SLOT_W'(pos);
            end
         end
      end
      result.entry_count = spq_pkg::COUNT_W'(stored_count);
      result.top_value = (stored_count > 0) ? stored_values[0] : '0;
      return result;
   endfunction

   function automatic logic signed [spq_pkg::VALUE_W-1:0] random_priority();
      logic signed [spq_pkg::VALUE_W-1:0] value;
      case ($urandom_range(3))
         0: value = int'($urandom_range(8)) - 4;
         1: begin
            case ($urandom_range(3))
               0: value = 32'sh7FFF_FFFF;
               1: value = 32'sh8000_0000;
               2: value = '0;
               default: value = -1;
            endcase
         end
         default: value = $urandom;
      endcase
      return value;
   endfunction

   task automatic send_command(input logic cmd,
                               input logic signed [spq_pkg::VALUE_W-1:0] value);
      spq_pkg::req_type txn;
      txn.command = cmd;
      txn.item_value = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= txn;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      expected_results.push_back(apply_queue_command(txn));
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result transaction with no expected result pending");
         end else begin
            want_rsp = expected_results.pop_front();
            if (rsp_data.status !== want_rsp.status) begin
               report_mismatch($sformatf("status got %0d expected %0d",
                                         rsp_data.status, want_rsp.status));
            end
            if (rsp_data.entry_count !== want_rsp.entry_count) begin
               report_mismatch($sformatf("entry_count got %0d expected %0d",
                                         rsp_data.entry_count, want_rsp.entry_count));
            end
            if (rsp_data.top_value !== want_rsp.top_value) begin
               report_mismatch($sformatf("top_value got %0d expected %0d",
                                         rsp_data.top_value, want_rsp.top_value));
            end
            if (rsp_data.slot !== want_rsp.slot) begin
               report_mismatch($sformatf("slot got %0d expected %0d",
                                         rsp_data.slot, want_rsp.slot));
            end
         end
      end
   end

   task automatic test_delete_when_empty();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_command(spq_pkg::CMD_DELETE, 32'sd0);
   endtask

   task automatic test_ordering_and_limits();
      send_command(spq_pkg::CMD_INSERT, 32'sd0);
      send_command(spq_pkg::CMD_INSERT, 32'sh7FFF_FFFF);
      send_command(spq_pkg::CMD_INSERT, 32'sh8000_0000);
      send_command(spq_pkg::CMD_INSERT, -32'sd1);
      send_command(spq_pkg::CMD_INSERT, 32'sd1);
      send_command(spq_pkg::CMD_INSERT, 32'sd0);
      send_command(spq_pkg::CMD_INSERT, 32'sd5);
      send_command(spq_pkg::CMD_INSERT, -32'sd5);
      send_command(spq_pkg::CMD_INSERT, 32'sd3);
      send_command(spq_pkg::CMD_DELETE, 32'sd0);
      send_command(spq_pkg::CMD_DELETE, 32'sd12345);
      send_command(spq_pkg::CMD_DELETE, 32'sh7FFF_FFFF);
      send_command(spq_pkg::CMD_DELETE, 32'sh8000_0000);
      while (stored_count > 0) begin
         send_command(spq_pkg::CMD_DELETE, stored_values[0]);
      end
      send_command(spq_pkg::CMD_DELETE, -32'sd1);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int item_total);
      int n;
      logic cmd;
      logic signed [spq_pkg::VALUE_W-1:0] value;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (n = 0; n < item_total; n++) begin
         if (stored_count == QUEUE_DEPTH) begin
            filling = 1'b0;
         end else if (stored_count == 0) begin
            filling = 1'b1;
         end
         cmd = ($urandom_range(99) < (filling ? 75 : 25)) ?
               spq_pkg::CMD_INSERT : spq_pkg::CMD_DELETE;
         if (cmd == spq_pkg::CMD_DELETE && stored_count > 0 && $urandom_range(99) < 75) begin
            value = stored_values[$urandom_range(stored_count - 1)];
         end else begin
            value = random_priority();
         end
         send_command(cmd, value);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_delete_when_empty();
      test_ordering_and_limits();
      test_random_traffic(0, 0, 110);
      test_random_traffic(65, 0, 110);
      test_random_traffic(0, 65, 110);
      test_random_traffic(12, 12, 110);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
